FILE: rtl/histogram_with_mode_query_core_assert.svh
// Assertion macros for the histogram RTL; only hwmq_back includes them.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef HISTOGRAM_WITH_MODE_QUERY_CORE_ASSERT_SVH
`define HISTOGRAM_WITH_MODE_QUERY_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge.
`define HWMQ_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define HWMQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/hwmq_pkg.sv
`timescale 1ns / 1ps

package hwmq_pkg;

	// Store geometry
	localparam int NUM_BINS    = 64;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_AW      = $clog2(NUM_BINS);
	localparam int USE_W       = $clog2(NUM_BINS + 1);

	// Fixed field widths
	localparam int REQ_W = 3;
	localparam int IDX_W = 6;
	localparam int ERR_W = 2;

	// Command queue depth between front and back
	localparam int QDEPTH = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ADD_SAMPLE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD_AMOUNT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SUB_AMOUNT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

	// Command kinds after classification
	localparam int KIND_W = 3;
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t CK_ADD     = 3'd0;
	localparam kind_t CK_SUB     = 3'd1;
	localparam kind_t CK_QUERY   = 3'd2;
	localparam kind_t CK_CLEAR   = 3'd3;
	localparam kind_t CK_OUTSIDE = 3'd4;

	// A count; the amount field shares this width
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// One classified command in the queue
	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   idx;
		count_t             amount;
	} cmd_t;

endpackage

FILE: rtl/hwmq_front.sv
`timescale 1ns / 1ps

module hwmq_front import hwmq_pkg::*; (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [IDX_W-1:0] bin_index,
	input  count_t           amount,
	output logic             push_valid,
	input  logic             push_ready,
	output cmd_t             push_cmd
);

	logic known;
	logic outside;

	// Flag a class beyond the store
	assign outside = ({1'b0, bin_index} >= (IDX_W + 1)'(NUM_BINS));

	// Classify the request into a command kind
	always_comb begin
		known           = 1'b1;
		push_cmd.idx    = bin_index;
		push_cmd.amount = amount;
		push_cmd.kind   = CK_ADD;
		unique case (req_type)
			REQ_ADD_SAMPLE: begin
				push_cmd.kind   = outside ? CK_OUTSIDE : CK_ADD;
				push_cmd.amount = count_t'(1);
			end
			REQ_ADD_AMOUNT: push_cmd.kind = outside ? CK_OUTSIDE : CK_ADD;
			REQ_SUB_AMOUNT: push_cmd.kind = outside ? CK_OUTSIDE : CK_SUB;
			REQ_QUERY:      push_cmd.kind = CK_QUERY;
			REQ_CLEAR:      push_cmd.kind = CK_CLEAR;
			default:        known = 1'b0;
		endcase
	end

	// Accept whenever the queue has room; drop unknown requests
	assign in_ready   = push_ready;
	assign push_valid = in_valid && known;

endmodule

FILE: rtl/hwmq_queue.sv
`timescale 1ns / 1ps

module hwmq_queue import hwmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/hwmq_back.sv
`timescale 1ns / 1ps
`include "histogram_with_mode_query_core_assert.svh"

module hwmq_back import hwmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  cmd_t             pop_cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] class_index,
	output count_t           class_count,
	output count_t           total_samples,
	output logic             last,
	output logic             none_found,
	output logic [ERR_W-1:0] error_flag
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPD    = 3'd1;
	localparam logic [2:0] ST_SINGLE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_P2_RD  = 3'd4;
	localparam logic [2:0] ST_P2_CMP = 3'd5;

	logic [2:0]        state_q;
	cmd_t              cmd_q;
	count_t            mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	count_t            rd_data_s1;
	logic              rd_bit_s1;
	logic              rd_vld_s1;
	logic [BIN_AW-1:0] rd_idx_s1;
	count_t            total_q;
	logic [USE_W-1:0]  inuse_q;
	count_t            best_q;
	logic [BIN_AW-1:0] last_idx_q;
	logic [USE_W-1:0]  ra_q;

	logic              out_vld_q;
	logic [IDX_W-1:0]  class_index_q;
	count_t            class_count_q;
	count_t            total_samples_q;
	logic              last_q;
	logic              none_found_q;
	logic [ERR_W-1:0]  error_flag_q;

	logic              rd_en;
	logic [BIN_AW-1:0] rd_addr;
	logic              out_free;
	count_t            eff;
	logic [COUNT_WIDTH:0] bin_sum;
	logic [COUNT_WIDTH:0] tot_sum;
	logic              is_add;
	logic              bin_ovf;
	logic              tot_ovf;
	logic              bin_unf;
	logic              tot_unf;
	count_t            new_bin;
	count_t            new_tot;
	logic [ERR_W-1:0]  new_err;
	logic [USE_W-1:0]  idx_plus;
	logic [USE_W-1:0]  new_use;
	logic              match;
	logic              is_last;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_free  = !out_vld_q || out_ready;
	assign eff       = rd_bit_s1 ? rd_data_s1 : '0;

	// Choose the read address for the bin memory
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pop_cmd.idx[BIN_AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				rd_en = pop_valid && (pop_cmd.kind == CK_ADD || pop_cmd.kind == CK_SUB);
			end
			ST_SCAN: begin
				rd_en   = (ra_q < inuse_q);
				rd_addr = ra_q[BIN_AW-1:0];
			end
			ST_P2_RD: begin
				rd_en   = 1'b1;
				rd_addr = ra_q[BIN_AW-1:0];
			end
			default: rd_en = 1'b0;
		endcase
	end

	// Work out the saturating update of one bin and the total
	always_comb begin
		is_add   = (cmd_q.kind == CK_ADD);
		bin_sum  = {1'b0, eff} + {1'b0, cmd_q.amount};
		tot_sum  = {1'b0, total_q} + {1'b0, cmd_q.amount};
		bin_ovf  = bin_sum[COUNT_WIDTH];
		tot_ovf  = tot_sum[COUNT_WIDTH];
		bin_unf  = (cmd_q.amount > eff);
		tot_unf  = (cmd_q.amount > total_q);
		if (is_add) begin
			new_bin = bin_ovf ? '1 : bin_sum[COUNT_WIDTH-1:0];
			new_tot = tot_ovf ? '1 : tot_sum[COUNT_WIDTH-1:0];
			new_err = (bin_ovf || tot_ovf) ? ERR_OVERFLOW : ERR_OK;
		end else begin
			new_bin = bin_unf ? '0 : eff - cmd_q.amount;
			new_tot = tot_unf ? '0 : total_q - cmd_q.amount;
			new_err = (bin_unf || tot_unf) ? ERR_UNDERFLOW : ERR_OK;
		end
		idx_plus = USE_W'(cmd_q.idx[BIN_AW-1:0]) + USE_W'(1);
		new_use  = (is_add && (inuse_q < idx_plus)) ? idx_plus : inuse_q;
	end

	assign match   = (eff == best_q);
	assign is_last = (ra_q[BIN_AW-1:0] == last_idx_q);

	// Bin memory with registered read; write back on an update
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && out_free) begin
			mem[cmd_q.idx[BIN_AW-1:0]] <= new_bin;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_bit_s1  <= vld_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Hold the command under execution
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cmd_q <= pop_cmd;
		end
	end

	// Sequence the commands and keep the store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			total_q    <= '0;
			inuse_q    <= '0;
			best_q     <= '0;
			last_idx_q <= '0;
			ra_q       <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						unique case (pop_cmd.kind) inside
							CK_ADD, CK_SUB: state_q <= ST_UPD;
							CK_QUERY: begin
								best_q  <= '0;
								ra_q    <= '0;
								state_q <= (inuse_q == '0) ? ST_SINGLE : ST_SCAN;
							end
							CK_CLEAR: begin
								vld_q   <= '0;
								total_q <= '0;
								inuse_q <= '0;
								state_q <= ST_SINGLE;
							end
							default: state_q <= ST_SINGLE;
						endcase
					end
				end
				ST_UPD: begin
					if (out_free) begin
						vld_q[cmd_q.idx[BIN_AW-1:0]] <= 1'b1;
						total_q <= new_tot;
						inuse_q <= new_use;
						state_q <= ST_IDLE;
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ra_q <= ra_q + USE_W'(1);
					end
					// Track the highest count and the last bin that holds it
					if (rd_vld_s1) begin
						if (eff > best_q) begin
							best_q     <= eff;
							last_idx_q <= rd_idx_s1;
						end else if (eff == best_q) begin
							last_idx_q <= rd_idx_s1;
						end
					end else if (!rd_en) begin
						ra_q    <= '0;
						state_q <= ST_P2_RD;
					end
				end
				ST_P2_RD: state_q <= ST_P2_CMP;
				ST_P2_CMP: begin
					if (!match) begin
						ra_q    <= ra_q + USE_W'(1);
						state_q <= ST_P2_RD;
					end else if (out_free) begin
						ra_q    <= ra_q + USE_W'(1);
						state_q <= is_last ? ST_IDLE : ST_P2_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (out_free) begin
			unique case (state_q)
				ST_UPD: begin
					class_index_q   <= cmd_q.idx;
					class_count_q   <= new_bin;
					total_samples_q <= new_tot;
					last_q          <= 1'b1;
					none_found_q    <= (new_use == '0);
					error_flag_q    <= new_err;
				end
				ST_SINGLE: begin
					class_index_q   <= (cmd_q.kind == CK_OUTSIDE) ? cmd_q.idx : '0;
					class_count_q   <= '0;
					total_samples_q <= total_q;
					last_q          <= 1'b1;
					none_found_q    <= (inuse_q == '0);
					error_flag_q    <= ERR_OK;
				end
				ST_P2_CMP: begin
					class_index_q   <= IDX_W'(ra_q[BIN_AW-1:0]);
					class_count_q   <= best_q;
					total_samples_q <= total_q;
					last_q          <= is_last;
					none_found_q    <= 1'b0;
					error_flag_q    <= ERR_OK;
				end
				default: ;
			endcase
		end
	end

	// Raise valid when a result is loaded; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free && (state_q == ST_UPD || state_q == ST_SINGLE ||
				(state_q == ST_P2_CMP && match))) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid     = out_vld_q;
	assign class_index   = class_index_q;
	assign class_count   = class_count_q;
	assign total_samples = total_samples_q;
	assign last          = last_q;
	assign none_found    = none_found_q;
	assign error_flag    = error_flag_q;

	`HWMQ_ASSERT(a_use_bound, inuse_q <= USE_W'(NUM_BINS), "bins in use beyond store")
	`HWMQ_ASSERT_IMP(a_upd_after_idle, state_q == ST_UPD, $past(state_q) == ST_IDLE || $past(state_q) == ST_UPD, "update without read")
	`HWMQ_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, ra_q <= inuse_q, "scan ran past bins in use")
	`HWMQ_ASSERT_IMP(a_emit_bound, state_q == ST_P2_RD || state_q == ST_P2_CMP, ra_q <= USE_W'(last_idx_q), "report pass ran past last tie")

endmodule

FILE: rtl/histogram_with_mode_query_core.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// input    in_valid / in_ready    req_type, bin_index, amount
// output   out_valid / out_ready  class_index, class_count, total_samples, last,
//                                 none_found, error_flag
// A two-entry command queue parts the front from the executing back end, so input
// is taken while the back end works or a result waits.
// Update: queue, registered bin read, then write back and result. Clear and
// single results: queue, then result. Query over the bins in use: a maximum
// search, then a second pass that re-reads each bin up to the last tied class;
// the bin memory has a single read port.
// Reset clears all bins at once through per-bin valid bits; there is no clearing pass.
// A stalled output holds the back end; the queue then fills and drops in_ready.

module histogram_with_mode_query_core import hwmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [IDX_W-1:0] bin_index,
	input  count_t           amount,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] class_index,
	output count_t           class_count,
	output count_t           total_samples,
	output logic             last,
	output logic             none_found,
	output logic [ERR_W-1:0] error_flag
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Classify incoming requests
	hwmq_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.bin_index  (bin_index),
		.amount     (amount),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Buffer commands between front and back
	hwmq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Execute commands against the store
	hwmq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_cmd       (pop_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.class_index   (class_index),
		.class_count   (class_count),
		.total_samples (total_samples),
		.last          (last),
		.none_found    (none_found),
		.error_flag    (error_flag)
	);

endmodule

FILE: tb/hwmq_result_checker.sv
`timescale 1ns / 1ps

module hwmq_result_checker import hwmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  logic [IDX_W-1:0] bin_index,
	input  count_t           amount,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [IDX_W-1:0] class_index,
	input  count_t           class_count,
	input  count_t           total_samples,
	input  logic             last,
	input  logic             none_found,
	input  logic [ERR_W-1:0] error_flag,
	output int               mismatch_count,
	output int               pending_count
);

	typedef struct packed {
		logic [IDX_W-1:0] cls;
		count_t           cnt;
		count_t           total;
		logic             last;
		logic             none;
		logic [ERR_W-1:0] err;
	} hist_result_t;

	// Shadow copy of the store
	count_t           bin_level [NUM_BINS];
	count_t           sample_sum;
	logic [USE_W-1:0] used_bins;

	hist_result_t expected_results [$];
	int           fail_tally = 0;

	task automatic clear_store();
		for (int i = 0; i < NUM_BINS; i++)
			bin_level[i] = '0;
		sample_sum = '0;
		used_bins  = '0;
	endtask

	// Append one expected result at the tail
	task automatic queue_result(input hist_result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	function automatic count_t sat_add(input count_t a, input count_t b, inout logic ovf);
		logic [COUNT_WIDTH:0] wide;
		wide = {1'b0, a} + {1'b0, b};
		if (wide[COUNT_WIDTH]) begin
			ovf = 1'b1;
			return '1;
		end
		return wide[COUNT_WIDTH-1:0];
	endfunction

	function automatic count_t sat_sub(input count_t a, input count_t b, inout logic unf);
		if (b > a) begin
			unf = 1'b1;
			return '0;
		end
		return a - b;
	endfunction

	// Apply one request to the shadow store and queue the results it causes
	task automatic predict_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
			input count_t amt);
		hist_result_t r;
		count_t       peak;
		count_t       step;
		logic         ovf;
		logic         unf;
		int           last_tie;
		ovf = 1'b0;
		unf = 1'b0;
		case (req)
		REQ_CLEAR: begin
			clear_store();
			r = '{cls: '0, cnt: '0, total: '0, last: 1'b1, none: 1'b1, err: ERR_OK};
			queue_result(r);
		end
		REQ_QUERY: begin
			if (used_bins == 0) begin
				r = '{cls: '0, cnt: '0, total: sample_sum, last: 1'b1, none: 1'b1, err: ERR_OK};
				queue_result(r);
			end else begin
				// Search starts at zero, so an all-zero store ties every bin in use
				peak     = '0;
				last_tie = 0;
				for (int i = 0; i < used_bins; i++)
					if (bin_level[i] > peak)
						peak = bin_level[i];
				for (int i = 0; i < used_bins; i++)
					if (bin_level[i] == peak)
						last_tie = i;
				for (int i = 0; i < used_bins; i++) begin
					if (bin_level[i] == peak) begin
						r = '{cls: i[IDX_W-1:0], cnt: peak, total: sample_sum,
							last: (i == last_tie), none: 1'b0, err: ERR_OK};
						queue_result(r);
					end
				end
			end
		end
		REQ_ADD_SAMPLE, REQ_ADD_AMOUNT: begin
			step = (req == REQ_ADD_SAMPLE) ? count_t'(1) : amt;
			bin_level[idx] = sat_add(bin_level[idx], step, ovf);
			sample_sum     = sat_add(sample_sum, step, ovf);
			if (used_bins < USE_W'(idx) + USE_W'(1))
				used_bins = USE_W'(idx) + USE_W'(1);
			r = '{cls: idx, cnt: bin_level[idx], total: sample_sum, last: 1'b1,
				none: (used_bins == 0), err: ovf ? ERR_OVERFLOW : ERR_OK};
			queue_result(r);
		end
		REQ_SUB_AMOUNT: begin
			bin_level[idx] = sat_sub(bin_level[idx], amt, unf);
			sample_sum     = sat_sub(sample_sum, amt, unf);
			r = '{cls: idx, cnt: bin_level[idx], total: sample_sum, last: 1'b1,
				none: (used_bins == 0), err: unf ? ERR_UNDERFLOW : ERR_OK};
			queue_result(r);
		end
		default: begin
			// Reserved codes are dropped without a result
		end
		endcase
	endtask

	// Compare the output transaction first, then predict from the input transaction
	always @(posedge clk or negedge arst_n) begin
		hist_result_t got;
		hist_result_t want;
		if (!arst_n) begin
			clear_store();
			expected_results.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{cls: class_index, cnt: class_count, total: total_samples, last: last,
					none: none_found, err: error_flag};
				if (expected_results.size() == 0) begin
					if (fail_tally < 10)
						$display("unexpected result: class %0d count %0d total %0d last %0b none %0b err %0d",
							got.cls, got.cnt, got.total, got.last, got.none, got.err);
					fail_tally = fail_tally + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (fail_tally < 10) begin
							$display("mismatch: expected class %0d count %0d total %0d last %0b none %0b err %0d",
								want.cls, want.cnt, want.total, want.last, want.none, want.err);
							$display("          actual   class %0d count %0d total %0d last %0b none %0b err %0d",
								got.cls, got.cnt, got.total, got.last, got.none, got.err);
						end
						fail_tally = fail_tally + 1;
					end
				end
			end
			if (in_valid && in_ready)
				predict_request(req_type, bin_index, amount);
			pending_count <= expected_results.size();
		end
		mismatch_count <= fail_tally;
	end

endmodule

FILE: tb/tb_histogram_with_mode_query_core.sv
`timescale 1ns / 1ps

module tb_histogram_with_mode_query_core;
	import hwmq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_RESERVED_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RESERVED_MID   = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RESERVED_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 270;
	localparam int TAIL_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 600000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [REQ_W-1:0] req_type = REQ_ADD_SAMPLE;
	logic [IDX_W-1:0] bin_index = '0;
	count_t           amount = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] class_index;
	count_t           class_count;
	count_t           total_samples;
	logic             last;
	logic             none_found;
	logic [ERR_W-1:0] error_flag;

	int mismatch_count;
	int pending_count;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	histogram_with_mode_query_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .bin_index(bin_index), .amount(amount),
		.out_valid(out_valid), .out_ready(out_ready),
		.class_index(class_index), .class_count(class_count),
		.total_samples(total_samples), .last(last),
		.none_found(none_found), .error_flag(error_flag)
	);

	hwmq_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .bin_index(bin_index), .amount(amount),
		.out_valid(out_valid), .out_ready(out_ready),
		.class_index(class_index), .class_count(class_count),
		.total_samples(total_samples), .last(last),
		.none_found(none_found), .error_flag(error_flag),
		.mismatch_count(mismatch_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver back-pressure: phases of full rate, light stalls and heavy stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0:       out_ready <= 1'b1;
		1:       out_ready <= ($urandom_range(0, 3) != 0);
		default: out_ready <= ($urandom_range(0, 9) < 3);
		endcase
	end

	// Hold one transaction until accepted, then maybe idle before the next burst
	task automatic push_request(input logic [REQ_W-1:0] r, input logic [IDX_W-1:0] b,
			input count_t a);
		int idle;
		in_valid  <= 1'b1;
		req_type  <= r;
		bin_index <= b;
		amount    <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left != 0) begin
			burst_left = burst_left - 1;
		end else begin
			burst_left = $urandom_range(0, 19);
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(negedge clk);
			end
		end
	endtask

	initial begin
		int               random_sent;
		int               roll;
		logic [REQ_W-1:0] r;
		logic [IDX_W-1:0] b;
		count_t           a;
		random_sent = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty store, saturation both ways, ties, reserved codes
		push_request(REQ_QUERY, 6'd0, 32'd0);
		push_request(REQ_SUB_AMOUNT, 6'd0, 32'd0);
		push_request(REQ_SUB_AMOUNT, 6'd0, 32'd1);
		push_request(REQ_ADD_SAMPLE, 6'd0, 32'd0);
		push_request(REQ_SUB_AMOUNT, 6'd40, 32'd3);
		push_request(REQ_ADD_AMOUNT, 6'd63, 32'hFFFF_FFFF);
		push_request(REQ_ADD_SAMPLE, 6'd63, 32'h0);
		push_request(REQ_QUERY, 6'd63, 32'hFFFF_FFFF);
		push_request(REQ_SUB_AMOUNT, 6'd63, 32'hFFFF_FFFF);
		push_request(REQ_QUERY, 6'd0, 32'd0);
		push_request(REQ_RESERVED_FIRST, 6'd1, 32'd1);
		push_request(REQ_RESERVED_MID, 6'd2, 32'd2);
		push_request(REQ_RESERVED_LAST, 6'd3, 32'd3);
		push_request(REQ_CLEAR, 6'd63, 32'hFFFF_FFFF);
		push_request(REQ_QUERY, 6'd0, 32'd0);
		push_request(REQ_ADD_AMOUNT, 6'd5, 32'd0);
		push_request(REQ_QUERY, 6'd0, 32'd0);
		push_request(REQ_ADD_AMOUNT, 6'd2, 32'd7);
		push_request(REQ_ADD_AMOUNT, 6'd4, 32'd7);
		push_request(REQ_QUERY, 6'd0, 32'd0);
		push_request(REQ_SUB_AMOUNT, 6'd2, 32'h8000_0000);
		push_request(REQ_ADD_AMOUNT, 6'd7, 32'hFFFF_FFFE);
		push_request(REQ_ADD_SAMPLE, 6'd7, 32'h0);
		push_request(REQ_CLEAR, 6'd0, 32'd0);

		// Random: mostly updates on a few low classes so ties and queries stay busy
		while (random_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 4) < 3)
				b = IDX_W'($urandom_range(0, 7));
			else
				b = IDX_W'($urandom_range(0, NUM_BINS - 1));
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: a = $urandom_range(0, 15);
			5, 6:          a = $urandom_range(0, 1023);
			7:             a = 32'hFFFF_FFFF - $urandom_range(0, 15);
			default:       a = $urandom();
			endcase
			if (roll < 40)
				r = REQ_ADD_SAMPLE;
			else if (roll < 60)
				r = REQ_ADD_AMOUNT;
			else if (roll < 75)
				r = REQ_SUB_AMOUNT;
			else if (roll < 89)
				r = REQ_QUERY;
			else if (roll < 94)
				r = REQ_CLEAR;
			else
				r = REQ_W'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
			push_request(r, b, a);
			if (roll < 94)
				random_sent = random_sent + 1;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && pending_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
